// ===== src/rbca_pkg.sv =====
// package with the shared types, widths and codes of the run blob accumulator
`timescale 1ns / 1ps
`default_nettype none
package rbca_pkg;

    localparam int MAX_BLOBS_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int LW            = 9;
    localparam int CW            = 10;
    localparam int SXW           = 29;
    localparam int SYW           = 28;
    localparam int PCW           = 20;
    localparam int IXW           = 4;

    typedef enum logic {
        OP_RUN = 1'b0,
        OP_EOF = 1'b1
    } t_op;

    typedef struct packed {
        t_op           operation;
        logic [LW-1:0] line_number;
        logic [CW-1:0] run_start;
        logic [CW-1:0] run_stop;
    } t_in;

    typedef struct packed {
        logic [SXW-1:0] blob_sum_x;
        logic [SYW-1:0] blob_sum_y;
        logic [PCW-1:0] pixel_count;
        logic [IXW-1:0] blob_index;
        logic           blob_present;
        logic           last_result;
        logic           overflow_seen;
    } t_out;

    // one slot record held in the table memory
    typedef struct packed {
        logic [LW-1:0]  prev_line;
        logic [CW-1:0]  prev_start;
        logic [CW-1:0]  prev_stop;
        logic [LW-1:0]  cur_line;
        logic [CW-1:0]  cur_start;
        logic [CW-1:0]  cur_stop;
        logic [SXW-1:0] sum_x;
        logic [SYW-1:0] sum_y;
        logic [PCW-1:0] pixels;
    } t_rec;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PASS,
        ST_FIN,
        ST_REP_RD,
        ST_REP_EX,
        ST_EMPTY,
        ST_CLEAR
    } t_state;

endpackage
`default_nettype wire

// ===== src/rbca_if.sv =====
// request channel interfaces for runs in and blob reports out
`timescale 1ns / 1ps
`default_nettype none
interface rbca_in_if;
    logic          valid;
    logic          ready;
    rbca_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rbca_out_if;
    logic           valid;
    logic           ready;
    rbca_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/run_blob_centroid_accumulator_core.sv =====
// top level: run grouping into blobs with centroid sums over a slot table memory
//
// i_run takes one request per run (line, start, stop) or an end-of-frame
// marker; o_blob gives one request per occupied slot (at most MAX_RESULTS) at
// end of frame, in slot order, with the last one marked, or one empty request
// for a frame with no blob. Run requests give nothing out.
// A run goes from its accept through a product set-up step, one sweep over
// the table memory with one slot read and written back per cycle, and a
// step that stores the joined or newly opened blob; no new request is taken
// before that store. The single read port of the slot memory makes the
// sweep serial. Inverted runs are accepted and dropped without a sweep.
// End of frame steps through a read state and a report state per slot up to
// the last reported one, then the table clear; an empty frame goes through
// the empty report state and the clear. The sweep waits while the receiver
// stalls: the report holds in the output register until that register frees.
// Reset clears the slot flags, the line tracking and the overflow flag; the
// slot memory itself needs no clearing since no entry's contents are used
// before that entry is written.
`timescale 1ns / 1ps
`default_nettype none
module run_blob_centroid_accumulator_core #(
    parameter int MAX_BLOBS = rbca_pkg::MAX_BLOBS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rbca_in_if.sink    i_run,
    rbca_out_if.source o_blob
);

    localparam int SW = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_BLOBS - 1);
    localparam logic [rbca_pkg::IXW-1:0] LAST_K = rbca_pkg::IXW'(rbca_pkg::MAX_RESULTS - 1);

    // saturating adders for the three sums
    function automatic logic [rbca_pkg::SXW-1:0] sat_x(input logic [rbca_pkg::SXW-1:0] a,
                                                       input logic [rbca_pkg::SXW-1:0] b);
        logic [rbca_pkg::SXW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[rbca_pkg::SXW] ? '1 : s[rbca_pkg::SXW-1:0];
    endfunction

    function automatic logic [rbca_pkg::SYW-1:0] sat_y(input logic [rbca_pkg::SYW-1:0] a,
                                                       input logic [rbca_pkg::SYW-1:0] b);
        logic [rbca_pkg::SYW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[rbca_pkg::SYW] ? '1 : s[rbca_pkg::SYW-1:0];
    endfunction

    function automatic logic [rbca_pkg::PCW-1:0] sat_p(input logic [rbca_pkg::PCW-1:0] a,
                                                       input logic [rbca_pkg::PCW-1:0] b);
        logic [rbca_pkg::PCW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[rbca_pkg::PCW] ? '1 : s[rbca_pkg::PCW-1:0];
    endfunction

    rbca_pkg::t_state r_state, n_state;
    logic [SW-1:0]        r_slot, n_slot;
    logic [MAX_BLOBS-1:0] r_active, n_active;
    logic [MAX_BLOBS-1:0] r_fin, n_fin;
    logic [MAX_BLOBS-1:0] r_pv, n_pv;
    logic [MAX_BLOBS-1:0] r_cs, n_cs;
    logic [rbca_pkg::LW-1:0] r_seen, n_seen;
    logic r_seen_v, n_seen_v;
    logic r_ovf, n_ovf;
    logic r_lc, n_lc;
    rbca_pkg::t_in r_run, n_run;
    logic [rbca_pkg::SXW-1:0] r_cx, n_cx;
    logic [rbca_pkg::SYW-1:0] r_cy, n_cy;
    logic [rbca_pkg::PCW-1:0] r_n, n_n;
    logic r_have_first, n_have_first;
    logic [SW-1:0] r_first, n_first;
    rbca_pkg::t_rec r_hold, n_hold;
    logic [rbca_pkg::IXW-1:0] r_k, n_k;
    rbca_pkg::t_out r_out, n_out;
    logic r_ov, n_ov;

    // slot table memory
    rbca_pkg::t_rec r_mem [MAX_BLOBS];
    rbca_pkg::t_rec r_rdata;
    logic           mem_we;
    logic [SW-1:0]  mem_waddr, mem_raddr;
    rbca_pkg::t_rec mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // run products
    logic [rbca_pkg::CW:0]     run_n;
    logic [2*rbca_pkg::CW+1:0] prod_x;
    logic [rbca_pkg::PCW-1:0]  prod_y;
    assign run_n  = {1'b0, r_run.run_stop} - {1'b0, r_run.run_start} + 11'd1;
    assign prod_x = {{(rbca_pkg::CW+1){1'b0}},
                     ({1'b0, r_run.run_start} + {1'b0, r_run.run_stop})}
                  * {{(rbca_pkg::CW+1){1'b0}}, run_n};
    assign prod_y = {{(rbca_pkg::PCW-rbca_pkg::LW){1'b0}}, r_run.line_number}
                  * {{(rbca_pkg::PCW-rbca_pkg::CW-1){1'b0}}, run_n};

    // lowest free slot
    logic          free_found;
    logic [SW-1:0] free_idx;
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_BLOBS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    // occupied slots above the current one
    logic [MAX_BLOBS-1:0] above;
    logic                 any_above;
    assign above     = r_active >> r_slot;
    assign any_above = |above[MAX_BLOBS-1:1];

    logic out_free;
    assign out_free = !r_ov || o_blob.ready;

    // per-slot view during the sweep
    rbca_pkg::t_rec rec_u, add_rec, new_rec;
    logic act, lcs, fin_u, pv_u, cs_u, match;
    logic [rbca_pkg::LW:0] line_x;
    assign line_x = {1'b0, r_run.line_number};

    always_comb begin
        act   = r_active[r_slot];
        lcs   = r_lc && act && !r_fin[r_slot];
        rec_u = r_rdata;
        fin_u = r_fin[r_slot];
        pv_u  = r_pv[r_slot];
        cs_u  = r_cs[r_slot];
        if (lcs) begin
            rec_u.prev_line  = r_rdata.cur_line;
            rec_u.prev_start = r_rdata.cur_start;
            rec_u.prev_stop  = r_rdata.cur_stop;
            pv_u  = 1'b1;
            cs_u  = 1'b0;
            fin_u = !(line_x == {1'b0, r_rdata.cur_line} ||
                      line_x == {1'b0, r_rdata.cur_line} + 10'd1);
        end
        match = act && !fin_u && pv_u &&
                (line_x == {1'b0, rec_u.prev_line} + 10'd1) &&
                (rec_u.prev_start < r_run.run_stop) &&
                (rec_u.prev_stop > r_run.run_start);
        // run joins this slot
        add_rec        = rec_u;
        add_rec.sum_x  = sat_x(rec_u.sum_x, r_cx);
        add_rec.sum_y  = sat_y(rec_u.sum_y, r_cy);
        add_rec.pixels = sat_p(rec_u.pixels, r_n);
        add_rec.cur_stop = r_run.run_stop;
        if (!cs_u) begin
            add_rec.cur_line  = r_run.line_number;
            add_rec.cur_start = r_run.run_start;
        end
        // freshly opened blob
        new_rec            = rec_u;
        new_rec.prev_line  = r_run.line_number;
        new_rec.prev_start = r_run.run_start;
        new_rec.prev_stop  = r_run.run_stop;
        new_rec.cur_line   = r_run.line_number;
        new_rec.cur_start  = r_run.run_start;
        new_rec.cur_stop   = r_run.run_stop;
        new_rec.sum_x      = r_cx;
        new_rec.sum_y      = r_cy;
        new_rec.pixels     = r_n;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_slot       = r_slot;
        n_active     = r_active;
        n_fin        = r_fin;
        n_pv         = r_pv;
        n_cs         = r_cs;
        n_seen       = r_seen;
        n_seen_v     = r_seen_v;
        n_ovf        = r_ovf;
        n_lc         = r_lc;
        n_run        = r_run;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_n          = r_n;
        n_have_first = r_have_first;
        n_first      = r_first;
        n_hold       = r_hold;
        n_k          = r_k;
        n_out        = r_out;
        n_ov         = r_ov && !o_blob.ready;
        mem_we       = 1'b0;
        mem_waddr    = r_slot;
        mem_wdata    = rec_u;
        mem_raddr    = r_slot;
        i_run.ready  = 1'b0;

        unique case (r_state)
            rbca_pkg::ST_IDLE: begin
                i_run.ready = 1'b1;
                if (i_run.valid) begin
                    n_run = i_run.data;
                    if (i_run.data.operation == rbca_pkg::OP_EOF) begin
                        n_slot  = '0;
                        n_k     = '0;
                        n_state = (r_active == '0) ? rbca_pkg::ST_EMPTY
                                                   : rbca_pkg::ST_REP_RD;
                    end else if (i_run.data.run_stop >= i_run.data.run_start) begin
                        n_lc     = !r_seen_v || (r_seen != i_run.data.line_number);
                        n_seen   = i_run.data.line_number;
                        n_seen_v = 1'b1;
                        n_state  = rbca_pkg::ST_LOAD;
                    end
                end
            end
            rbca_pkg::ST_LOAD: begin
                n_cx         = rbca_pkg::SXW'(prod_x >> 1);
                n_cy         = rbca_pkg::SYW'(prod_y);
                n_n          = rbca_pkg::PCW'(run_n);
                n_have_first = 1'b0;
                n_slot       = '0;
                mem_raddr    = '0;
                n_state      = rbca_pkg::ST_PASS;
            end
            rbca_pkg::ST_PASS: begin
                if (match && !r_have_first) begin
                    n_have_first  = 1'b1;
                    n_first       = r_slot;
                    n_hold        = add_rec;
                    n_fin[r_slot] = fin_u;
                    n_pv[r_slot]  = pv_u;
                    n_cs[r_slot]  = 1'b1;
                end else if (match) begin
                    // merge into the first matching blob and free this slot
                    n_hold.prev_stop = rec_u.prev_stop;
                    n_hold.sum_x     = sat_x(r_hold.sum_x, rec_u.sum_x);
                    n_hold.sum_y     = sat_y(r_hold.sum_y, rec_u.sum_y);
                    n_hold.pixels    = sat_p(r_hold.pixels, rec_u.pixels);
                    n_active[r_slot] = 1'b0;
                    n_fin[r_slot]    = 1'b0;
                    n_pv[r_slot]     = 1'b0;
                    n_cs[r_slot]     = 1'b0;
                end else if (lcs) begin
                    mem_we        = 1'b1;
                    n_fin[r_slot] = fin_u;
                    n_pv[r_slot]  = pv_u;
                    n_cs[r_slot]  = cs_u;
                end
                if (r_slot == LAST_SLOT) begin
                    n_state = rbca_pkg::ST_FIN;
                end else begin
                    n_slot    = r_slot + 1'b1;
                    mem_raddr = r_slot + 1'b1;
                end
            end
            rbca_pkg::ST_FIN: begin
                if (r_have_first) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_first;
                    mem_wdata = r_hold;
                end else if (free_found) begin
                    mem_we             = 1'b1;
                    mem_waddr          = free_idx;
                    mem_wdata          = new_rec;
                    n_active[free_idx] = 1'b1;
                    n_fin[free_idx]    = 1'b0;
                    n_pv[free_idx]     = 1'b0;
                    n_cs[free_idx]     = 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_state = rbca_pkg::ST_IDLE;
            end
            rbca_pkg::ST_REP_RD: begin
                n_state = rbca_pkg::ST_REP_EX;
            end
            rbca_pkg::ST_REP_EX: begin
                if (!act) begin
                    n_slot  = r_slot + 1'b1;
                    n_state = (r_slot == LAST_SLOT) ? rbca_pkg::ST_CLEAR
                                                    : rbca_pkg::ST_REP_RD;
                end else if (out_free) begin
                    n_ov                = 1'b1;
                    n_out.blob_sum_x    = r_rdata.sum_x;
                    n_out.blob_sum_y    = r_rdata.sum_y;
                    n_out.pixel_count   = r_rdata.pixels;
                    n_out.blob_index    = r_k;
                    n_out.blob_present  = 1'b1;
                    n_out.last_result   = (r_k == LAST_K) || !any_above;
                    n_out.overflow_seen = r_ovf;
                    n_k                 = r_k + 1'b1;
                    n_slot              = r_slot + 1'b1;
                    n_state = ((r_k == LAST_K) || !any_above) ? rbca_pkg::ST_CLEAR
                                                              : rbca_pkg::ST_REP_RD;
                end
            end
            rbca_pkg::ST_EMPTY: begin
                if (out_free) begin
                    n_ov                = 1'b1;
                    n_out               = '0;
                    n_out.last_result   = 1'b1;
                    n_out.overflow_seen = r_ovf;
                    n_state             = rbca_pkg::ST_CLEAR;
                end
            end
            rbca_pkg::ST_CLEAR: begin
                n_active = '0;
                n_fin    = '0;
                n_pv     = '0;
                n_cs     = '0;
                n_ovf    = 1'b0;
                n_state  = rbca_pkg::ST_IDLE;
            end
            default: begin
                n_state = rbca_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rbca_pkg::ST_IDLE;
            r_active     <= '0;
            r_fin        <= '0;
            r_pv         <= '0;
            r_cs         <= '0;
            r_seen       <= '0;
            r_seen_v     <= 1'b0;
            r_ovf        <= 1'b0;
            r_have_first <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_active     <= n_active;
            r_fin        <= n_fin;
            r_pv         <= n_pv;
            r_cs         <= n_cs;
            r_seen       <= n_seen;
            r_seen_v     <= n_seen_v;
            r_ovf        <= n_ovf;
            r_have_first <= n_have_first;
            r_ov         <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_lc    <= n_lc;
        r_run   <= n_run;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_n     <= n_n;
        r_first <= n_first;
        r_hold  <= n_hold;
        r_k     <= n_k;
        r_out   <= n_out;
    end

    assign o_blob.valid = r_ov;
    assign o_blob.data  = r_out;

    // checks
    a_fin_only_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin & ~r_active) == '0)
        else $error("finished flag on a free slot");

    a_first_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rbca_pkg::ST_FIN && r_have_first) |-> r_active[r_first])
        else $error("joined blob slot is not occupied");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rbca_pkg::ST_CLEAR |=> (r_active == '0 && !r_ovf))
        else $error("table not cleared after report");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_blob.valid && !o_blob.data.blob_present) |-> o_blob.data.last_result)
        else $error("empty report not marked last");

endmodule
`default_nettype wire
